// ===== hw/rtl/r2fft_pkg.sv =====
// ----------------------------------------------------------------------------
// r2fft_pkg
// shared constants, types and helpers for the radix-2 fft
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int POINTS = 32;
    localparam int HALF_POINTS = POINTS / 2;
    localparam int ADDR_W = $clog2(POINTS);
    localparam int TW_ADDR_W = (HALF_POINTS > 1) ? $clog2(HALF_POINTS) : 1;
    localparam int DATA_W = 32;
    localparam int TW_W = 16;

    localparam logic [1:0] OP_TWIDDLE = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_RUN     = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_BOT,
        ST_MUL,
        ST_RND,
        ST_WR_TOP,
        ST_WR_BOT,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+3:0] x);
        logic signed [DATA_W+3:0] hi;
        logic signed [DATA_W+3:0] lo;
        begin
            hi = (DATA_W+4)'(2147483647);
            lo = -(DATA_W+4)'(2147483647) - (DATA_W+4)'(1);
            if (x > hi)
                sat32 = DATA_W'(hi);
            else if (x < lo)
                sat32 = DATA_W'(lo);
            else
                sat32 = x[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/radix2_dit_fft.sv =====
// ----------------------------------------------------------------------------
// radix2_dit_fft
// in-place radix-2 decimation-in-time fft with one shared butterfly datapath
// ----------------------------------------------------------------------------
// Twiddle and sample writes are taken only while idle. A run walks
// POINTS/2*log2(POINTS) butterflies (80 for 32 points) through a single shared
// complex multiplier; each butterfly steps through read bottom, multiply, round,
// write top and write bottom, with the top read overlapping the previous write,
// because one read and one write port serve the data memory. The run is then
// followed by POINTS result transactions, each passing through the emit read,
// emit wait and emit states (memory read plus output register).
// Input is not ready from run acceptance until the last result is taken.
module radix2_dit_fft
    import r2fft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], index[7:2], value_re[23:8], value_im[39:24]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bin_index[5:0], out_re[37:6], out_im[69:38], pad
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    state_t state_reg, state_next;

    logic [1:0]  in_op;
    logic [5:0]  in_idx;
    logic signed [15:0] in_re, in_im;
    assign in_op  = s_axis_tdata[1:0];
    assign in_idx = s_axis_tdata[7:2];
    assign in_re  = s_axis_tdata[23:8];
    assign in_im  = s_axis_tdata[39:24];

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // run counters
    logic [ADDR_W:0]   span_reg, span_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] bfly_reg, bfly_next;
    logic [ADDR_W-1:0] grp_reg, grp_next;
    logic [ADDR_W-1:0] emit_reg, emit_next;

    logic [ADDR_W:0]   half;
    logic [ADDR_W-1:0] top_addr, bot_addr;
    assign half     = span_reg >> 1;
    assign top_addr = base_reg + bfly_reg;
    assign bot_addr = top_addr + half[ADDR_W-1:0];

    // memories
    logic              d_we;
    logic [ADDR_W-1:0] d_waddr, d_raddr;
    logic [63:0]       d_wdata, d_rdata;
    logic              t_we;
    logic [TW_ADDR_W-1:0] t_waddr, t_raddr;
    logic [31:0]       t_wdata, t_rdata;

    r2fft_ram #(.WIDTH(64), .DEPTH(POINTS)) u_data_ram (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    r2fft_ram #(.WIDTH(32), .DEPTH((HALF_POINTS > 1) ? HALF_POINTS : 2)) u_tw_ram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    // datapath registers
    logic signed [31:0] ur_reg, ui_reg;
    logic signed [48:0] pr_reg, pi_reg;
    logic signed [34:0] tr_reg, ti_reg;
    logic [71:0] out_data_reg;
    logic        out_last_reg;
    logic        out_valid_reg;

    logic signed [15:0] wr, wi;
    logic signed [31:0] ar, ai;
    assign wr = t_rdata[15:0];
    assign wi = t_rdata[31:16];
    assign ar = d_rdata[31:0];
    assign ai = d_rdata[63:32];

    // full-width partial products of the complex multiply
    logic signed [47:0] prod_rr, prod_ii, prod_ri, prod_ir;
    assign prod_rr = wr * ar;
    assign prod_ii = wi * ai;
    assign prod_ri = wr * ai;
    assign prod_ir = wi * ar;

    logic last_bfly, last_group, last_stage;
    assign last_bfly  = ({1'b0, bfly_reg} == half - 1'b1);
    assign last_group = ({1'b0, base_reg} + span_reg == (ADDR_W+1)'(POINTS));
    assign last_stage = (span_reg == (ADDR_W+1)'(2));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire && in_op == OP_RUN)
                    state_next = ST_RD_BOT;
            ST_RD_BOT:    state_next = ST_MUL;
            ST_MUL:       state_next = ST_RND;
            ST_RND:       state_next = ST_WR_TOP;
            ST_WR_TOP:    state_next = ST_WR_BOT;
            ST_WR_BOT:
                if (last_bfly && last_group && last_stage)
                    state_next = ST_EMIT_RD;
                else
                    state_next = ST_RD_BOT;
            ST_EMIT_RD:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT: state_next = ST_EMIT;
            ST_EMIT:
                if (m_axis_tready)
                    state_next = (emit_reg == ADDR_W'(POINTS - 1)) ? ST_IDLE : ST_EMIT_RD;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        span_next = span_reg;
        base_next = base_reg;
        bfly_next = bfly_reg;
        grp_next  = grp_reg;
        emit_next = emit_reg;
        d_we    = 1'b0;
        d_waddr = top_addr;
        d_wdata = '0;
        d_raddr = top_addr;
        t_we    = 1'b0;
        t_waddr = in_idx[TW_ADDR_W-1:0];
        t_wdata = {in_im, in_re};
        t_raddr = grp_reg[TW_ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_op == OP_SAMPLE && {2'b0, in_idx} < 8'(POINTS))
                begin
                    d_we    = 1'b1;
                    d_waddr = in_idx[ADDR_W-1:0];
                    d_wdata = {{16{in_im[15]}}, in_im, {16{in_re[15]}}, in_re};
                end
                if (in_fire && in_op == OP_TWIDDLE && {2'b0, in_idx} < 8'(HALF_POINTS))
                    t_we = 1'b1;
                if (in_fire && in_op == OP_RUN)
                begin
                    span_next = (ADDR_W+1)'(POINTS);
                    base_next = '0;
                    bfly_next = '0;
                    grp_next  = '0;
                    emit_next = '0;
                end
            end
            ST_RD_BOT: d_raddr = bot_addr;
            ST_WR_TOP:
            begin
                d_we    = 1'b1;
                d_waddr = top_addr;
                d_wdata = {sat32(36'(ui_reg) + 36'(ti_reg)), sat32(36'(ur_reg) + 36'(tr_reg))};
            end
            ST_WR_BOT:
            begin
                d_we    = 1'b1;
                d_waddr = bot_addr;
                d_wdata = {sat32(36'(ui_reg) - 36'(ti_reg)), sat32(36'(ur_reg) - 36'(tr_reg))};
                if (!last_bfly)
                    bfly_next = bfly_reg + 1'b1;
                else
                begin
                    bfly_next = '0;
                    if (!last_group)
                    begin
                        base_next = ADDR_W'({1'b0, base_reg} + span_reg);
                        grp_next  = grp_reg + 1'b1;
                    end
                    else
                    begin
                        base_next = '0;
                        grp_next  = '0;
                        span_next = last_stage ? '0 : (span_reg >> 1);
                    end
                end
                // next top read for the following butterfly
                d_raddr = ADDR_W'(base_next + bfly_next);
                t_raddr = grp_next[TW_ADDR_W-1:0];
            end
            ST_EMIT_RD: d_raddr = emit_reg;
            ST_EMIT_WAIT: d_raddr = emit_reg;
            ST_EMIT:
            begin
                d_raddr = emit_reg;
                if (m_axis_tready)
                    emit_next = emit_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // top operand is captured in the cycle after its read is issued
    logic top_cap;
    assign top_cap = (state_reg == ST_RD_BOT);

    always_ff @(posedge clk)
    begin
        if (top_cap)
        begin
            ur_reg <= ar;
            ui_reg <= ai;
        end
        if (state_reg == ST_MUL)
        begin
            pr_reg <= 49'(prod_rr) - 49'(prod_ii);
            pi_reg <= 49'(prod_ri) + 49'(prod_ir);
        end
        if (state_reg == ST_RND)
        begin
            tr_reg <= 35'((pr_reg + 49'sd8192) >>> 14);
            ti_reg <= 35'((pi_reg + 49'sd8192) >>> 14);
        end
        if (state_reg == ST_EMIT_WAIT)
        begin
            out_data_reg <= {2'b0, d_rdata[63:32], d_rdata[31:0], 6'(emit_reg)};
            out_last_reg <= (emit_reg == ADDR_W'(POINTS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            span_reg      <= '0;
            base_reg      <= '0;
            bfly_reg      <= '0;
            grp_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            span_reg      <= span_next;
            base_reg      <= base_next;
            bfly_reg      <= bfly_next;
            grp_reg       <= grp_next;
            emit_reg      <= emit_next;
            out_valid_reg <= (state_next == ST_EMIT);
        end
    end

    // run entry also issues the first top read via default address (zero)
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input ready while busy");
    a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (state_reg == ST_EMIT))
        else $error("output valid outside emit");
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (state_reg == ST_IDLE))
        else $error("run did not end after last result");
    a_span_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (span_reg >= (ADDR_W+1)'(2)))
        else $error("butterfly with bad span");
`endif

endmodule

// ===== hw/rtl/r2fft_ram.sv =====
// ----------------------------------------------------------------------------
// r2fft_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module r2fft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
